>>> src/m3inv_pkg.sv
// types and constants shared by the 3x3 matrix inverse pipeline
`default_nettype none
package m3inv_pkg;

    // element formats
    localparam int IN_WIDTH  = 16;
    localparam int IN_FRAC   = 8;
    localparam int OUT_WIDTH = 32;
    localparam int OUT_FRAC  = 16;
    localparam int QSHIFT    = IN_FRAC + OUT_FRAC;

    // internal widths, exact for the element width above
    localparam int PROD_W = 2 * IN_WIDTH;
    localparam int ADJ_W  = PROD_W + 1;
    localparam int DET_W  = ADJ_W + IN_WIDTH + 2;
    localparam int NUM_W  = ADJ_W + QSHIFT;
    localparam int QW     = OUT_WIDTH + 1;
    localparam int LANES  = 9;

    // saturation limits on the quotient magnitude
    localparam logic [QW-1:0] SAT_NEG = QW'(1) << (OUT_WIDTH - 1);
    localparam logic [QW-1:0] SAT_POS = SAT_NEG - QW'(1);

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] a00;
        logic signed [IN_WIDTH-1:0] a01;
        logic signed [IN_WIDTH-1:0] a02;
        logic signed [IN_WIDTH-1:0] a10;
        logic signed [IN_WIDTH-1:0] a11;
        logic signed [IN_WIDTH-1:0] a12;
        logic signed [IN_WIDTH-1:0] a20;
        logic signed [IN_WIDTH-1:0] a21;
        logic signed [IN_WIDTH-1:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] b00;
        logic signed [OUT_WIDTH-1:0] b01;
        logic signed [OUT_WIDTH-1:0] b02;
        logic signed [OUT_WIDTH-1:0] b10;
        logic signed [OUT_WIDTH-1:0] b11;
        logic signed [OUT_WIDTH-1:0] b12;
        logic signed [OUT_WIDTH-1:0] b20;
        logic signed [OUT_WIDTH-1:0] b21;
        logic signed [OUT_WIDTH-1:0] b22;
        logic                        singular;
    } inv_t;

    // one divider lane: numerator bits still to shift in, partial remainder, quotient
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DET_W-1:0] rem;
        logic [QW-1:0]    q;
        logic             ovf;
        logic             neg;
    } lane_t;

    typedef struct packed {
        lane_t [LANES-1:0] lane;
        logic [DET_W-1:0]  nd;
        logic              sing;
    } stage_t;

endpackage
`default_nettype wire

>>> src/matrix3x3_inverse.sv
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// Usage:
//   mat channel (mat_valid, mat_stall, mat) takes one matrix of nine signed
//   Q8.8 elements per request. inv channel (inv_valid, inv_stall, inv) returns
//   the inverse in signed Q16.16, each element adj*2^24/det truncated toward
//   zero and saturated, plus a singular flag that zeroes all elements.
// From an accepted request to inv_valid: four stages
//   form products, cofactors, determinant terms and the determinant, one
//   stage takes magnitudes, 57 restoring divide stages (one quotient bit per
//   stage, nine lanes side by side) produce the quotients, and one stage
//   saturates and applies the sign.
// Throughput is one matrix per cycle while the receiver does not stall; the divide chain sets the latency.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls a valid result, the whole pipeline holds and
//   mat_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module matrix3x3_inverse
    import m3inv_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic mat_valid,
    output logic      mat_stall,
    input  wire mat_t mat,
    output logic      inv_valid,
    input  wire logic inv_stall,
    output inv_t      inv
);

    // one restoring divide step
    function automatic lane_t div_step(lane_t l, logic [DET_W-1:0] nd);
        lane_t          o;
        logic [DET_W:0] sh;
        o     = l;
        sh    = {l.rem, l.num[NUM_W-1]};
        o.num = {l.num[NUM_W-2:0], 1'b0};
        o.ovf = l.ovf | l.q[QW-1];
        if (sh >= {1'b0, nd})
        begin
            o.rem = DET_W'(sh - {1'b0, nd});
            o.q   = {l.q[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = sh[DET_W-1:0];
            o.q   = {l.q[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // saturate and apply the sign
    function automatic logic [OUT_WIDTH-1:0] finish(lane_t l, logic sing);
        logic [QW-1:0] lim;
        logic [QW-1:0] qsel;
        lim  = l.neg ? SAT_NEG : SAT_POS;
        qsel = (l.ovf || (l.q > lim)) ? lim : l.q;
        if (sing)
            return '0;
        else if (l.neg)
            return OUT_WIDTH'(QW'(0) - qsel);
        else
            return qsel[OUT_WIDTH-1:0];
    endfunction

    logic adv;
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic out_v_reg;
    logic [NUM_W:0] div_v_reg;

    logic signed [PROD_W-1:0]          prod_reg [0:2*LANES-1];
    logic signed [IN_WIDTH-1:0]        r1_reg [0:2];
    logic signed [ADJ_W-1:0]           adj2_reg [0:LANES-1];
    logic signed [IN_WIDTH-1:0]        r2_reg [0:2];
    logic signed [ADJ_W-1:0]           adj3_reg [0:LANES-1];
    logic signed [IN_WIDTH+ADJ_W-1:0]  dp_reg [0:2];
    logic signed [ADJ_W-1:0]           adj4_reg [0:LANES-1];
    logic signed [DET_W-1:0]           det_reg;
    stage_t                            div_reg [0:NUM_W];
    stage_t                            div0_next;
    inv_t                              inv_reg;

    // whole pipeline moves unless a held result is stalled
    assign adv       = !out_v_reg || !inv_stall;
    assign mat_stall = !adv;
    assign inv_valid = out_v_reg;
    assign inv       = inv_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            div_v_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= mat_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            div_v_reg <= {div_v_reg[NUM_W-1:0], s4_v_reg};
            out_v_reg <= div_v_reg[NUM_W];
        end
    end

    // stage 1: cofactor products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg[0]  <= mat.a11 * mat.a22;
            prod_reg[1]  <= mat.a12 * mat.a21;
            prod_reg[2]  <= mat.a02 * mat.a21;
            prod_reg[3]  <= mat.a01 * mat.a22;
            prod_reg[4]  <= mat.a01 * mat.a12;
            prod_reg[5]  <= mat.a02 * mat.a11;
            prod_reg[6]  <= mat.a12 * mat.a20;
            prod_reg[7]  <= mat.a10 * mat.a22;
            prod_reg[8]  <= mat.a00 * mat.a22;
            prod_reg[9]  <= mat.a02 * mat.a20;
            prod_reg[10] <= mat.a02 * mat.a10;
            prod_reg[11] <= mat.a00 * mat.a12;
            prod_reg[12] <= mat.a10 * mat.a21;
            prod_reg[13] <= mat.a11 * mat.a20;
            prod_reg[14] <= mat.a01 * mat.a20;
            prod_reg[15] <= mat.a00 * mat.a21;
            prod_reg[16] <= mat.a00 * mat.a11;
            prod_reg[17] <= mat.a01 * mat.a10;
            r1_reg[0]    <= mat.a00;
            r1_reg[1]    <= mat.a01;
            r1_reg[2]    <= mat.a02;
        end
    end

    // stages 2 to 4: adjugate, determinant terms, determinant
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                adj2_reg[k] <= ADJ_W'(prod_reg[2*k]) - ADJ_W'(prod_reg[2*k+1]);
                adj3_reg[k] <= adj2_reg[k];
                adj4_reg[k] <= adj3_reg[k];
            end
            r2_reg    <= r1_reg;
            dp_reg[0] <= r2_reg[0] * adj2_reg[0];
            dp_reg[1] <= r2_reg[1] * adj2_reg[3];
            dp_reg[2] <= r2_reg[2] * adj2_reg[6];
            det_reg   <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
        end
    end

    // stage 5: magnitudes and signs into the divider
    always_comb
    begin
        div0_next.nd   = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        div0_next.sing = (det_reg == '0);
        for (int k = 0; k < LANES; k++)
        begin
            div0_next.lane[k].num = {(adj4_reg[k][ADJ_W-1] ? ADJ_W'(-adj4_reg[k])
                                                           : ADJ_W'(adj4_reg[k])),
                                     {QSHIFT{1'b0}}};
            div0_next.lane[k].rem = '0;
            div0_next.lane[k].q   = '0;
            div0_next.lane[k].ovf = 1'b0;
            div0_next.lane[k].neg = adj4_reg[k][ADJ_W-1] ^ det_reg[DET_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg[0] <= div0_next;
    end

    // divide stages, one quotient bit each
    for (genvar s = 0; s < NUM_W; s++)
    begin : g_div
        stage_t step_next;
        always_comb
        begin
            step_next.nd   = div_reg[s].nd;
            step_next.sing = div_reg[s].sing;
            for (int k = 0; k < LANES; k++)
                step_next.lane[k] = div_step(div_reg[s].lane[k], div_reg[s].nd);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                div_reg[s+1] <= step_next;
        end
    end

    // output stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inv_reg.b00      <= finish(div_reg[NUM_W].lane[0], div_reg[NUM_W].sing);
            inv_reg.b01      <= finish(div_reg[NUM_W].lane[1], div_reg[NUM_W].sing);
            inv_reg.b02      <= finish(div_reg[NUM_W].lane[2], div_reg[NUM_W].sing);
            inv_reg.b10      <= finish(div_reg[NUM_W].lane[3], div_reg[NUM_W].sing);
            inv_reg.b11      <= finish(div_reg[NUM_W].lane[4], div_reg[NUM_W].sing);
            inv_reg.b12      <= finish(div_reg[NUM_W].lane[5], div_reg[NUM_W].sing);
            inv_reg.b20      <= finish(div_reg[NUM_W].lane[6], div_reg[NUM_W].sing);
            inv_reg.b21      <= finish(div_reg[NUM_W].lane[7], div_reg[NUM_W].sing);
            inv_reg.b22      <= finish(div_reg[NUM_W].lane[8], div_reg[NUM_W].sing);
            inv_reg.singular <= div_reg[NUM_W].sing;
        end
    end

    // singular result carries zeros in b00, b01, b11, b20 and b22
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |-> inv.b00 == '0 && inv.b11 == '0 && inv.b22 == '0
                                      && inv.b01 == '0 && inv.b20 == '0)
        else $error("singular result with nonzero element");

    // a stalled result freezes the last divide stage and stage 1
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> $stable(div_v_reg[NUM_W]) && $stable(s1_v_reg))
        else $error("pipeline moved under stall");

    // an accepted request enters stage 1
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && !mat_stall |=> s1_v_reg)
        else $error("accepted request lost at entry");

    // an unstalled output with an empty last divide stage holds no result afterwards
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !inv_stall && !div_v_reg[NUM_W] |=> !inv_valid)
        else $error("result appeared without a source");

endmodule
`default_nettype wire
